// ===== rtl/core/icfs_pkg.sv =====
package icfs_pkg;

   // Fixed widths of the stream fields.
   localparam int MASK_W   = 4;
   localparam int COUNTS_W = 32;
   localparam int THREAD_W = 2;

   // Upper ends of the parameter ranges and the defaults.
   localparam int MAX_THREADS      = 8;
   localparam int MAX_COUNT_BITS   = 8;
   localparam int DEF_THREADS      = 4;
   localparam int DEF_COUNT_BITS   = 8;
   localparam int COUNTS_EXT_W     = MAX_THREADS * MAX_COUNT_BITS;

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = ((MASK_W + COUNTS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((1 + THREAD_W + 7) / 8) * 8;

   // Command codes.
   localparam logic CMD_EVALUATE = 1'b0;
   localparam logic CMD_COMMIT   = 1'b1;

   // One request item.
   typedef struct packed {
      logic                command;
      logic [MASK_W-1:0]   active_mask;
      logic [COUNTS_W-1:0] frontend_counts;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic                found;
      logic [THREAD_W-1:0] thread;
   } rsp_item_type;

endpackage

// ===== rtl/core/icount_thread_fetch_select.sv =====
// Channel   Direction  Ports              Contents
// req       in         req_tvalid/tready  tuser: command; tdata: mask, counts
// rsp       out        rsp_tvalid/tready  tdata: found, thread
//
// Items pass the request and the result register; one item per cycle unless stalled.
// The selection is a chain of THREADS compares between the request register
// and the result register, and the pointer updates as the item moves on.
// Reset is synchronous and clears the pointer, the stored choice and both
// valid flags. A stalled result holds the request register; both stay full.
module icount_thread_fetch_select
   import icfs_pkg::*;
#(
   parameter int THREADS    = DEF_THREADS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // active_mask[3:0], frontend_counts[35:4], zero
   input  logic                  req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // found[0], thread[2:1], zero
);

   localparam int PTR_W = $clog2(THREADS);

   req_item_type     req_item;
   req_item_type     stage_item;
   rsp_item_type     sel_result;
   rsp_item_type     rsp_item;
   logic             stage_valid;
   logic             stage_ready;
   logic             advance;
   logic [PTR_W-1:0] choice;

   // Unpack the request transfer.
   assign req_item.command         = req_tuser;
   assign req_item.active_mask     = req_tdata[MASK_W-1:0];
   assign req_item.frontend_counts = req_tdata[MASK_W +: COUNTS_W];

   icfs_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   assign advance = stage_valid && stage_ready;

   icfs_select #(
      .THREADS    (THREADS),
      .COUNT_BITS (COUNT_BITS)
   ) u_select (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_item),
      .result  (sel_result),
      .choice  (choice)
   );

   icfs_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_ready  (stage_ready),
      .in_item   (sel_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // Pack the result transfer.
   assign rsp_tdata = {{(RSP_DATA_W - 1 - THREAD_W){1'b0}}, rsp_item.thread, rsp_item.found};

   // A request waiting on a stalled result stays in the register.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid && !stage_ready |=> stage_valid)
      else $error("request register dropped an item while the result was stalled");

   // No active thread reports thread zero.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[2:1] == 2'b00)
      else $error("result without a thread carries a nonzero index");

   // A commit with an active thread reports the stored choice.
   a_commit_choice: assert property (@(posedge clock) disable iff (reset)
      advance && stage_item.command == CMD_COMMIT && sel_result.found
      |=> rsp_item.thread == $past(sel_result.thread) &&
          {2'b00, $past(choice)} == (PTR_W + 2)'(rsp_item.thread) || THREADS > 4)
      else $error("commit did not report the stored choice");

   // An evaluate with an active thread stores what it reports.
   a_eval_store: assert property (@(posedge clock) disable iff (reset)
      advance && stage_item.command == CMD_EVALUATE && sel_result.found
      |=> (PTR_W + 2)'(choice) == (PTR_W + 2)'(rsp_item.thread) || THREADS > 4)
      else $error("evaluate stored a different choice than it reported");

endmodule

// ===== rtl/core/icfs_in_reg.sv =====
module icfs_in_reg
   import icfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output req_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // The register takes a new transfer when empty or when its item moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== rtl/core/icfs_select.sv =====
module icfs_select
   import icfs_pkg::*;
#(
   parameter int THREADS    = DEF_THREADS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  req_item_type               item,
   output rsp_item_type               result,
   output logic [$clog2(THREADS)-1:0] choice
);

   localparam int PTR_W = $clog2(THREADS);
   localparam logic [PTR_W:0] THREADS_W = (PTR_W + 1)'(THREADS);
   localparam logic [PTR_W-1:0] LAST_THREAD = PTR_W'(THREADS - 1);

   logic [PTR_W-1:0]        rotate_ptr_ff;
   logic [PTR_W-1:0]        rotate_ptr_in;
   logic [PTR_W-1:0]        choice_ff;
   logic [PTR_W-1:0]        choice_in;
   logic [MAX_THREADS-1:0]  mask_ext;
   logic [THREADS-1:0]      mask_sel;
   logic [COUNTS_EXT_W-1:0] counts_ext;
   logic [COUNT_BITS-1:0]   count_of [THREADS];
   logic [PTR_W-1:0]        order_idx [THREADS];
   logic                    any_active;
   logic [PTR_W-1:0]        target;
   logic [COUNT_BITS-1:0]   best_count;
   logic [PTR_W+1:0]        report_wide;

   // Mask bits and counts beyond the input fields read as zero.
   assign mask_ext   = {{(MAX_THREADS - MASK_W){1'b0}}, item.active_mask};
   assign mask_sel   = mask_ext[THREADS-1:0];
   assign counts_ext = {{(COUNTS_EXT_W - COUNTS_W){1'b0}}, item.frontend_counts};

   for (genvar t = 0; t < THREADS; t++) begin : g_count
      assign count_of[t] = counts_ext[t*COUNT_BITS +: COUNT_BITS];
   end

   // Thread visited at each step of the rotation from the pointer.
   always_comb begin
      logic [PTR_W:0] sum;
      for (int k = 0; k < THREADS; k++) begin
         sum = {1'b0, rotate_ptr_ff} + (PTR_W + 1)'(k);
         if (sum >= THREADS_W) begin
            sum = sum - THREADS_W;
         end
         order_idx[k] = sum[PTR_W-1:0];
      end
   end

   // First active thread in rotation is the candidate; a strictly smaller
   // count later in rotation replaces it, so ties keep the earlier thread.
   always_comb begin
      any_active = 1'b0;
      target     = '0;
      best_count = '0;
      for (int k = 0; k < THREADS; k++) begin
         if (mask_sel[order_idx[k]]) begin
            if (!any_active || (count_of[order_idx[k]] < best_count)) begin
               target     = order_idx[k];
               best_count = count_of[order_idx[k]];
            end
            any_active = 1'b1;
         end
      end
   end

   // Result and state update for the item in the input register.
   always_comb begin
      rotate_ptr_in = rotate_ptr_ff;
      choice_in     = choice_ff;
      report_wide   = '0;
      result.found  = any_active;
      if (!any_active) begin
         if (item.command == CMD_COMMIT) begin
            rotate_ptr_in = (rotate_ptr_ff == LAST_THREAD) ? '0 : rotate_ptr_ff + 1'b1;
         end
      end else if (item.command == CMD_COMMIT) begin
         report_wide   = {2'b00, choice_ff};
         rotate_ptr_in = (choice_ff == LAST_THREAD) ? '0 : choice_ff + 1'b1;
      end else begin
         report_wide = {2'b00, target};
         choice_in   = target;
      end
      result.thread = report_wide[THREAD_W-1:0];
   end

   assign choice = choice_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_ptr_ff <= '0;
         choice_ff     <= '0;
      end else if (advance) begin
         rotate_ptr_ff <= rotate_ptr_in;
         choice_ff     <= choice_in;
      end
   end

endmodule

// ===== rtl/core/icfs_out_reg.sv =====
module icfs_out_reg
   import icfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // A held result is replaced only once the consumer takes its transfer.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule
